@@ src/cfsa_pkg.sv @@
package cfsa_pkg;

  localparam int unsigned SlotW  = 10;
  localparam int unsigned OffW   = 26;
  localparam int unsigned ChunkW = 11;
  localparam int unsigned ElemW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgChunkSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgElemSize  = 1'b1;

  localparam logic [ChunkW-1:0] ChunkSizeRst = 11'd64;
  localparam logic [ElemW-1:0]  ElemSizeRst  = 16'd16;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FREED = 2'd1,
    ST_OOM   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_PUSH,
    K_DROP,
    K_POP,
    K_FRESH,
    K_OPEN,
    K_OOM
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_pop;
    logic mul;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
  } dp_status_t;

endpackage

@@ src/cfsa_ctrl.sv @@
module cfsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  cfsa_pkg::dp_status_t status_i,
  output cfsa_pkg::cmd_t       cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  cfsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfsa_pkg::S_IDLE: begin
        if (start_i) begin
          if (status_i.kind == cfsa_pkg::K_POP) begin
            state_d = cfsa_pkg::S_POP;
          end else begin
            state_d = cfsa_pkg::S_MUL;
          end
        end
      end
      cfsa_pkg::S_POP: state_d = cfsa_pkg::S_MUL;
      cfsa_pkg::S_MUL: state_d = cfsa_pkg::S_OUT;
      cfsa_pkg::S_OUT: state_d = cfsa_pkg::S_IDLE;
      default:         state_d = cfsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      cfsa_pkg::S_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      cfsa_pkg::S_POP: cmd_o.load_pop = 1'b1;
      cfsa_pkg::S_MUL: cmd_o.mul = 1'b1;
      cfsa_pkg::S_OUT: done_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> done_o)
    else $error("multiply not followed by result strobe");

endmodule

@@ src/cfsa_dp.sv @@
module cfsa_dp #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cfsa_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cfsa_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                req_type_i,
  input  logic [cfsa_pkg::SlotW-1:0]          free_slot_i,
  input  cfsa_pkg::cmd_t                      cmd_i,
  output cfsa_pkg::dp_status_t                status_o,
  output logic [cfsa_pkg::SlotW-1:0]          slot_o,
  output logic [cfsa_pkg::OffW-1:0]           byte_offset_o,
  output logic [1:0]                          status_code_o,
  output logic                                opened_chunk_o
);

  localparam int unsigned IdxW = (POOL_SLOTS > 2) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned GotW = (IdxW > cfsa_pkg::SlotW) ? IdxW : cfsa_pkg::SlotW;
  localparam int unsigned SumW = ((CntW > cfsa_pkg::ChunkW) ? CntW : cfsa_pkg::ChunkW) + 1;
  localparam int unsigned MulW = GotW + cfsa_pkg::ElemW;

  logic [cfsa_pkg::ChunkW-1:0] chunk_q;
  logic [cfsa_pkg::ElemW-1:0]  elem_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [CntW-1:0]             next_q, next_d;
  logic [CntW-1:0]             end_q, end_d;

  logic [cfsa_pkg::SlotW-1:0]  mem [POOL_SLOTS];
  logic [cfsa_pkg::SlotW-1:0]  rd_q;

  logic [GotW-1:0]             got_q, got_d;
  cfsa_pkg::status_e           code_q, code_d;
  logic                        opened_q, opened_d;
  logic [cfsa_pkg::OffW-1:0]   prod_q;
  logic [MulW-1:0]             prod;

  logic [cfsa_pkg::ChunkW-1:0] cs;
  logic [SumW-1:0]             open_sum;
  cfsa_pkg::kind_e             kind;

  assign cs       = (chunk_q == '0) ? cfsa_pkg::ChunkW'(1) : chunk_q;
  assign open_sum = SumW'(end_q) + SumW'(cs);

  always_comb begin
    if (req_type_i == cfsa_pkg::ReqFree) begin
      kind = (count_q == CntW'(POOL_SLOTS)) ? cfsa_pkg::K_DROP : cfsa_pkg::K_PUSH;
    end else if (count_q != '0) begin
      kind = cfsa_pkg::K_POP;
    end else if (next_q < end_q) begin
      kind = cfsa_pkg::K_FRESH;
    end else if (open_sum <= SumW'(POOL_SLOTS)) begin
      kind = cfsa_pkg::K_OPEN;
    end else begin
      kind = cfsa_pkg::K_OOM;
    end
  end

  assign status_o.kind = kind;

  always_comb begin
    count_d  = count_q;
    next_d   = next_q;
    end_d    = end_q;
    got_d    = '0;
    code_d   = cfsa_pkg::ST_ALLOC;
    opened_d = 1'b0;
    unique case (kind)
      cfsa_pkg::K_PUSH: begin
        count_d = count_q + CntW'(1);
        code_d  = cfsa_pkg::ST_FREED;
      end
      cfsa_pkg::K_DROP: code_d = cfsa_pkg::ST_FREED;
      cfsa_pkg::K_POP:  count_d = count_q - CntW'(1);
      cfsa_pkg::K_FRESH: begin
        got_d  = GotW'(next_q);
        next_d = next_q + CntW'(1);
      end
      cfsa_pkg::K_OPEN: begin
        got_d    = GotW'(end_q);
        end_d    = CntW'(open_sum);
        next_d   = end_q + CntW'(1);
        opened_d = 1'b1;
      end
      cfsa_pkg::K_OOM: code_d = cfsa_pkg::ST_OOM;
      default: code_d = cfsa_pkg::ST_OOM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= cfsa_pkg::ChunkSizeRst;
      elem_q  <= cfsa_pkg::ElemSizeRst;
      count_q <= '0;
      next_q  <= '0;
      end_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cfsa_pkg::CfgChunkSize: chunk_q <= cfg_data_i[cfsa_pkg::ChunkW-1:0];
          cfsa_pkg::CfgElemSize:  elem_q  <= cfg_data_i[cfsa_pkg::ElemW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        count_q <= count_d;
        next_q  <= next_d;
        end_q   <= end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (kind == cfsa_pkg::K_PUSH)) begin
      mem[IdxW'(count_q)] <= free_slot_i;
    end
    if (cmd_i.accept && (kind == cfsa_pkg::K_POP)) begin
      rd_q <= mem[IdxW'(count_q - CntW'(1))];
    end
  end

  assign prod = MulW'(got_q) * MulW'(elem_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      got_q    <= got_d;
      code_q   <= code_d;
      opened_q <= opened_d;
    end else if (cmd_i.load_pop) begin
      got_q <= GotW'(rd_q);
    end
    if (cmd_i.mul) begin
      prod_q <= prod[cfsa_pkg::OffW-1:0];
    end
  end

  assign slot_o         = cfsa_pkg::SlotW'(got_q);
  assign byte_offset_o  = prod_q;
  assign status_code_o  = code_q;
  assign opened_chunk_o = opened_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(POOL_SLOTS))
    else $error("free stack count beyond pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= end_q)
    else $error("fresh pointer past chunk end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && kind == cfsa_pkg::K_OPEN) |=> (end_q >= next_q))
    else $error("opened chunk ends before its first fresh slot");

endmodule

@@ src/chunked_free_list_slot_allocator.sv @@
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
// request   in         start_i & !busy_o         req_type_i, free_slot_i
// result    out        done_o (one-cycle strobe) slot_o, byte_offset_o, status_o,
//                                                opened_chunk_o
//
// After acceptance a free, fresh slot, chunk open or out of memory passes through
// S_MUL to S_OUT, where the result is taken; a pop passes S_POP, S_MUL, S_OUT.
// busy_o drops the cycle after the strobe. S_POP holds the registered free-stack
// read and S_MUL the registered offset multiply.
// rst_ni clears counters and loads chunk_size 64, elem_size 16; no clear pass.
// The receiver cannot stall: results are dropped if not taken on the strobe.
module chunked_free_list_slot_allocator #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cfsa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cfsa_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [cfsa_pkg::SlotW-1:0]   free_slot_i,
  output logic                         done_o,
  output logic [cfsa_pkg::SlotW-1:0]   slot_o,
  output logic [cfsa_pkg::OffW-1:0]    byte_offset_o,
  output logic [1:0]                   status_o,
  output logic                         opened_chunk_o
);

  cfsa_pkg::cmd_t       cmd;
  cfsa_pkg::dp_status_t dp_status;

  cfsa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  cfsa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .free_slot_i    (free_slot_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .slot_o         (slot_o),
    .byte_offset_o  (byte_offset_o),
    .status_code_o  (status_o),
    .opened_chunk_o (opened_chunk_o)
  );

endmodule

@@ test/tb_chunked_free_list_slot_allocator.sv @@
`timescale 1ns / 1ps

module tb_chunked_free_list_slot_allocator;

  localparam int unsigned PoolSlots = 1024;

  typedef struct packed {
    logic [cfsa_pkg::SlotW-1:0] slot;
    logic [cfsa_pkg::OffW-1:0]  offset;
    cfsa_pkg::status_e          status;
    logic                       opened;
  } grant_t;

  class alloc_tracker #(int unsigned Pool = 1024);
    logic [cfsa_pkg::SlotW-1:0] lifo [Pool];
    int unsigned depth;
    int unsigned fresh_next;
    int unsigned fresh_limit;
    int unsigned chunk_cfg;
    int unsigned elem_cfg;
    int unsigned errors;
    grant_t      due_grants [$];

    function new();
      depth       = 0;
      fresh_next  = 0;
      fresh_limit = 0;
      chunk_cfg   = cfsa_pkg::ChunkSizeRst;
      elem_cfg    = cfsa_pkg::ElemSizeRst;
      errors      = 0;
    endfunction

    function void write_reg(logic [cfsa_pkg::CfgIdxW-1:0] idx,
                            logic [cfsa_pkg::CfgW-1:0] data);
      if (idx == cfsa_pkg::CfgChunkSize) begin
        chunk_cfg = data[cfsa_pkg::ChunkW-1:0];
      end else begin
        elem_cfg = data[cfsa_pkg::ElemW-1:0];
      end
    endfunction

    // note an accepted transaction and queue the grant it must produce
    function grant_t take_request(logic rtype, logic [cfsa_pkg::SlotW-1:0] fslot);
      grant_t g;
      int unsigned cs;
      longint unsigned prod;
      g = '0;
      if (rtype == cfsa_pkg::ReqFree) begin
        if (depth < Pool) begin
          lifo[depth] = fslot;
          depth++;
        end
        g.status = cfsa_pkg::ST_FREED;
      end else if (depth > 0) begin
        depth--;
        g.slot   = lifo[depth];
        g.status = cfsa_pkg::ST_ALLOC;
      end else if (fresh_next < fresh_limit) begin
        g.slot   = cfsa_pkg::SlotW'(fresh_next);
        fresh_next++;
        g.status = cfsa_pkg::ST_ALLOC;
      end else begin
        cs = (chunk_cfg == 0) ? 1 : chunk_cfg;
        if (fresh_limit + cs <= Pool) begin
          g.slot      = cfsa_pkg::SlotW'(fresh_limit);
          fresh_next  = fresh_limit + 1;
          fresh_limit = fresh_limit + cs;
          g.opened    = 1'b1;
          g.status    = cfsa_pkg::ST_ALLOC;
        end else begin
          g.status = cfsa_pkg::ST_OOM;
        end
      end
      if (g.status == cfsa_pkg::ST_ALLOC) begin
        prod     = longint'(g.slot) * elem_cfg;
        g.offset = cfsa_pkg::OffW'(prod);
      end
      due_grants.push_back(g);
      return g;
    endfunction

    task mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch on %s: want %0h got %0h", $time, what, want, got);
      errors++;
    endtask

    task match_grant(logic [cfsa_pkg::SlotW-1:0] s, logic [cfsa_pkg::OffW-1:0] o,
                     logic [1:0] st, logic op);
      grant_t g;
      if (due_grants.size() == 0) begin
        mismatch("result with no transaction pending", 0, st);
        return;
      end
      g = due_grants.pop_front();
      if (s !== g.slot) mismatch("slot", g.slot, s);
      if (o !== g.offset) mismatch("byte_offset", g.offset, o);
      if (st !== g.status) mismatch("status code", g.status, st);
      if (op !== g.opened) mismatch("opened_chunk", g.opened, op);
    endtask
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [cfsa_pkg::CfgIdxW-1:0]   cfg_idx_i   = cfsa_pkg::CfgChunkSize;
  logic [cfsa_pkg::CfgW-1:0]      cfg_data_i  = '0;
  logic                           start_i     = 1'b0;
  logic                           req_type_i  = cfsa_pkg::ReqAlloc;
  logic [cfsa_pkg::SlotW-1:0]     free_slot_i = '0;
  logic                           busy_o;
  logic                           done_o;
  logic [cfsa_pkg::SlotW-1:0]     slot_o;
  logic [cfsa_pkg::OffW-1:0]      byte_offset_o;
  logic [1:0]                     status_o;
  logic                           opened_chunk_o;

  alloc_tracker #(PoolSlots)      tracker;
  logic [cfsa_pkg::SlotW-1:0]     held [$];
  int unsigned                    burst_left = 0;

  chunked_free_list_slot_allocator #(
    .POOL_SLOTS(PoolSlots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .free_slot_i    (free_slot_i),
    .done_o         (done_o),
    .slot_o         (slot_o),
    .byte_offset_o  (byte_offset_o),
    .status_o       (status_o),
    .opened_chunk_o (opened_chunk_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.match_grant(slot_o, byte_offset_o, status_o, opened_chunk_o);
    end
  end

  task automatic wait_drained();
    start_i <= 1'b0;
    while (tracker.due_grants.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [cfsa_pkg::CfgIdxW-1:0] idx,
                           logic [cfsa_pkg::CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // upper data bits above the 11-bit chunk register are junk on purpose
  task automatic set_config(int unsigned cs, int unsigned es);
    wait_drained();
    write_reg(cfsa_pkg::CfgChunkSize, {5'($urandom), 11'(cs)});
    write_reg(cfsa_pkg::CfgElemSize, 16'(es));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(logic rtype, logic [cfsa_pkg::SlotW-1:0] fslot, output grant_t g);
    start_i     <= 1'b1;
    req_type_i  <= rtype;
    free_slot_i <= fslot;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    g = tracker.take_request(rtype, fslot);
    if (g.status == cfsa_pkg::ST_ALLOC) held.push_back(g.slot);
  endtask

  task automatic feed(logic rtype, logic [cfsa_pkg::SlotW-1:0] fslot, output grant_t g);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send(rtype, fslot, g);
  endtask

  // mostly return a slot that is really out; sometimes a bogus one
  function automatic logic [cfsa_pkg::SlotW-1:0] pick_victim();
    int unsigned k;
    logic [cfsa_pkg::SlotW-1:0] s;
    if (held.size() != 0 && $urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, held.size() - 1);
      s = held[k];
      held.delete(k);
    end else begin
      s = cfsa_pkg::SlotW'($urandom);
    end
    return s;
  endfunction

  task automatic run_phase(int unsigned n, int unsigned free_pct);
    grant_t g;
    repeat (n) begin
      if ($urandom_range(1, 100) <= free_pct) begin
        feed(cfsa_pkg::ReqFree, pick_victim(), g);
      end else begin
        feed(cfsa_pkg::ReqAlloc, cfsa_pkg::SlotW'($urandom), g);
      end
    end
  endtask

  initial begin : stimulus
    grant_t g;
    int unsigned cs;
    int unsigned es;
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    feed(cfsa_pkg::ReqAlloc, '0, g);
    feed(cfsa_pkg::ReqAlloc, '1, g);
    feed(cfsa_pkg::ReqFree, 10'h3FF, g);
    feed(cfsa_pkg::ReqFree, 10'h000, g);
    feed(cfsa_pkg::ReqFree, 10'h2AA, g);
    feed(cfsa_pkg::ReqFree, 10'h155, g);
    repeat (5) feed(cfsa_pkg::ReqAlloc, cfsa_pkg::SlotW'($urandom), g);
    set_config(2047, 65535);
    feed(cfsa_pkg::ReqAlloc, '0, g);
    feed(cfsa_pkg::ReqFree, 10'h3FF, g);
    feed(cfsa_pkg::ReqAlloc, '0, g);
    set_config(0, 0);
    feed(cfsa_pkg::ReqAlloc, '1, g);
    feed(cfsa_pkg::ReqFree, 10'h001, g);
    feed(cfsa_pkg::ReqAlloc, '0, g);
    set_config(64, 1);
    feed(cfsa_pkg::ReqAlloc, '0, g);

    run_phase(120, 20);
    repeat (7) begin
      case ($urandom_range(0, 7))
        0: cs = 0;
        1: cs = 1;
        2: cs = 1024;
        3: cs = 2047;
        default: cs = $urandom_range(2, 48);
      endcase
      case ($urandom_range(0, 5))
        0: es = 0;
        1: es = 1;
        2: es = 65535;
        default: es = $urandom_range(2, 65534);
      endcase
      set_config(cs, es);
      run_phase(70, $urandom_range(20, 60));
    end

    // pool end: one slot too many, then an exact fit
    set_config(PoolSlots + 1 - tracker.fresh_limit, tracker.elem_cfg);
    do feed(cfsa_pkg::ReqAlloc, cfsa_pkg::SlotW'($urandom), g);
    while (g.status != cfsa_pkg::ST_OOM);
    if (tracker.fresh_limit < PoolSlots) begin
      set_config(PoolSlots - tracker.fresh_limit, 65535);
      feed(cfsa_pkg::ReqAlloc, '0, g);
      run_phase(40, 30);
    end

    run_phase(60, 10);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
src/cfsa_pkg.sv
src/cfsa_ctrl.sv
src/cfsa_dp.sv
src/chunked_free_list_slot_allocator.sv
test/tb_chunked_free_list_slot_allocator.sv
